>>> design/servo_command_pwm_calibrator_defines.svh
// ---------------------------------------------------------------------------
// Servo command PWM calibrator assertion macros
// Shared concurrent assertion forms used by the calibrator RTL.
// ---------------------------------------------------------------------------
`ifndef SERVO_COMMAND_PWM_CALIBRATOR_DEFINES_SVH
`define SERVO_COMMAND_PWM_CALIBRATOR_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define SCPWM_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset
`define SCPWM_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> design/scpwm_pkg.sv
// ---------------------------------------------------------------------------
// Servo command PWM calibrator package
// Constants, calibration table, payload types and sequencer states.
// ---------------------------------------------------------------------------
`default_nettype none

package scpwm_pkg;

  localparam int CHANNELS   = 3;
  localparam int CAL_POINTS = 10;
  localparam int DIGITS     = 4;
  localparam int LAST_POS   = 1 + CHANNELS * DIGITS;

  localparam int IDX_W  = $clog2(LAST_POS + 1);
  localparam int CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int DIG_W  = (DIGITS > 1) ? $clog2(DIGITS) : 1;
  localparam int PT_W   = $clog2(CAL_POINTS);
  localparam int CAL_W  = 12;
  localparam int ACC_W  = 19;
  localparam int CMP_W  = 16;
  localparam int BYTE_W = 8;
  localparam int WGT_W  = 10;

  localparam int ASCII_ZERO = 48;
  localparam int SEG_SPAN   = 1000;
  localparam int HALF_SPAN  = SEG_SPAN / 2;
  localparam int ANGLE_TOP  = (CAL_POINTS - 1) * SEG_SPAN;

  // Divide-by-segment unit sizing
  localparam int T_W        = $clog2(SEG_SPAN);
  localparam int QUOT_W     = 12;
  localparam int DIVIDEND_W = 22;
  localparam int PROD_W     = CAL_W + 1 + T_W + 1;
  localparam int BASE_W     = CAL_W + T_W;
  localparam int SUM_W      = PROD_W + 1;

  // Reciprocal of the segment span: ceil(2^32 / 1000), exact for any
  // dividend below 2^DIVIDEND_W
  localparam int                 RECIP_SH = 32;
  localparam int                 RECIP_W  = 23;
  localparam logic [RECIP_W-1:0] RECIP_M  = 23'd4294968;

  localparam logic [CMP_W-1:0] PERIOD_RESET = 16'd20000;
  localparam logic [CMP_W-1:0] NEUTRAL_CMP  = 16'd18500;

  // Command bytes
  localparam logic [BYTE_W-1:0] CMD_NONE = 8'h00;
  localparam logic [BYTE_W-1:0] CMD_REV  = 8'h72;
  localparam logic [BYTE_W-1:0] CMD_FWD  = 8'h66;
  localparam logic [BYTE_W-1:0] CMD_A    = 8'h61;
  localparam logic [BYTE_W-1:0] CMD_B    = 8'h62;
  localparam logic [BYTE_W-1:0] CMD_C    = 8'h63;

  // Result status codes
  localparam logic [2:0] STAT_IGNORED = 3'd0;
  localparam logic [2:0] STAT_REVERSE = 3'd1;
  localparam logic [2:0] STAT_FORWARD = 3'd2;
  localparam logic [2:0] STAT_DIRECT  = 3'd3;
  localparam logic [2:0] STAT_UNKNOWN = 3'd4;

  // [direction: 0 reverse, 1 forward][channel][point], pulse in ticks
  localparam logic [CAL_W-1:0] CAL_TAB [2][CHANNELS][CAL_POINTS] = '{
    '{
      '{12'd2400, 12'd2310, 12'd2228, 12'd2130, 12'd2025,
        12'd1935, 12'd1840, 12'd1740, 12'd1640, 12'd1535},
      '{12'd2410, 12'd2330, 12'd2234, 12'd2150, 12'd2052,
        12'd1978, 12'd1865, 12'd1770, 12'd1650, 12'd1565},
      '{12'd2410, 12'd2320, 12'd2220, 12'd2140, 12'd2040,
        12'd1960, 12'd1860, 12'd1755, 12'd1640, 12'd1515}
    },
    '{
      '{12'd650,  12'd760,  12'd860,  12'd960,  12'd1055,
        12'd1150, 12'd1240, 12'd1330, 12'd1420, 12'd1510},
      '{12'd665,  12'd765,  12'd865,  12'd965,  12'd1060,
        12'd1150, 12'd1245, 12'd1340, 12'd1430, 12'd1525},
      '{12'd645,  12'd745,  12'd845,  12'd945,  12'd1040,
        12'd1130, 12'd1225, 12'd1315, 12'd1410, 12'd1500}
    }
  };

  typedef struct packed {
    logic [BYTE_W-1:0] message_byte;
    logic              end_of_message;
  } msg_t;

  typedef struct packed {
    logic [2:0]       status;
    logic [2:0]       update_mask;
    logic [CMP_W-1:0] compare_a;
    logic [CMP_W-1:0] compare_b;
    logic [CMP_W-1:0] compare_c;
  } res_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic [QUOT_W-1:0] quot;
    logic [T_W-1:0]    rem;
  } div_stat_t;

  typedef enum logic [3:0] {
    SQ_IDLE,
    SQ_DECODE,
    SQ_CHAN,
    SQ_KDIV,
    SQ_MUL,
    SQ_SUM,
    SQ_PDIV,
    SQ_APPLY,
    SQ_DONE
  } seq_state_t;

  // Weight of digit d: 10^(DIGITS-1-d)
  function automatic logic [WGT_W-1:0] digit_weight(input logic [DIG_W-1:0] d);
    logic [WGT_W-1:0] w;
    w = WGT_W'(1);
    for (int i = 1; i < DIGITS; i++) begin
      if (i > int'(d)) begin
        w = WGT_W'(int'(w) * 10);
      end
    end
    return w;
  endfunction

  function automatic int weight_sum();
    int s;
    s = 0;
    for (int d = 0; d < DIGITS; d++) begin
      s = s + int'(digit_weight(DIG_W'(d)));
    end
    return s;
  endfunction

  // Accumulator value of a message whose digit bytes are all zero
  localparam logic signed [ACC_W-1:0] ACC_INIT = ACC_W'(-ASCII_ZERO * weight_sum());

  function automatic logic [CAL_W-1:0] cal_point(input logic dir,
                                                 input logic [CH_W-1:0] ch,
                                                 input logic [PT_W-1:0] k);
    logic [CAL_W-1:0] p;
    p = '0;
    if (int'(ch) < CHANNELS && int'(k) < CAL_POINTS) begin
      p = CAL_TAB[dir][ch][k];
    end
    return p;
  endfunction

endpackage

`default_nettype wire

>>> design/scpwm_div1k.sv
// ---------------------------------------------------------------------------
// Segment divider
// Divide by the segment span through a reciprocal product: the dividend is latched, then the quotient is registered.
// ---------------------------------------------------------------------------
`default_nettype none
`include "servo_command_pwm_calibrator_defines.svh"

module scpwm_div1k (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic [scpwm_pkg::DIVIDEND_W-1:0]    dividend,
  output scpwm_pkg::div_stat_t                stat
);
  import scpwm_pkg::*;

  logic                            busy;
  logic                            done;
  logic [DIVIDEND_W-1:0]           num;
  logic [QUOT_W-1:0]               quot;
  logic [DIVIDEND_W+RECIP_W-1:0]   prod;
  logic [DIVIDEND_W-1:0]           rem;

  always_comb begin
    prod = (DIVIDEND_W + RECIP_W)'(num) * (DIVIDEND_W + RECIP_W)'(RECIP_M);
    rem  = num - DIVIDEND_W'(quot) * DIVIDEND_W'(SEG_SPAN);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      busy <= start;
      done <= busy;
    end
  end

  // Latch the dividend, then take the quotient from the reciprocal product
  always_ff @(posedge clk) begin
    if (start) begin
      num <= dividend;
    end
    if (busy) begin
      quot <= prod[RECIP_SH +: QUOT_W];
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;
  assign stat.quot = quot;
  assign stat.rem  = rem[T_W-1:0];

  `SCPWM_ASSERT_IMP(a_rem_range, clk, rst, done, rem < DIVIDEND_W'(SEG_SPAN), "remainder not below span")
  `SCPWM_ASSERT_IMP(a_no_restart, clk, rst, start, !busy, "divider restarted while busy")
  `SCPWM_ASSERT_IMP(a_done_on_fall, clk, rst, $fell(busy), done, "divider stopped without done")

endmodule

`default_nettype wire

>>> design/servo_command_pwm_calibrator.sv
// ---------------------------------------------------------------------------
// Servo command PWM calibrator
// Byte-wise command decoder with calibrated angle-to-compare mapping.
// ---------------------------------------------------------------------------
// Usage:
//   msg channel: one message byte per request, end_of_message on the last.
//     Non-final bytes are taken one per cycle; msg_ready is high while idle.
//   res channel: one result per message, issued after the final byte.
//   cfg channel: writes period; always ready, write only while idle.
// Sequence after the final byte: an ignored or unknown command goes to the
//   result directly, a direct channel command applies its one channel. For
//   'r' or 'f' each channel is clamped and applied if its angle lies outside
//   the table, else it goes through select, segment divide, multiply, sum,
//   rounding divide and apply. The shared divide-by-1000 unit serves the
//   three channels one after the other.
// Throughput: one byte per cycle within a message; one message at a time.
// Reset: period 20000, compare values 18500, message state cleared.
// Receiver stall: the result register holds until taken; the block takes
//   the next message bytes meanwhile, but waits before issuing a second
//   result until the first has gone.
// ---------------------------------------------------------------------------
`default_nettype none
`include "servo_command_pwm_calibrator_defines.svh"

module servo_command_pwm_calibrator (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              msg_valid,
  output logic                              msg_ready,
  input  scpwm_pkg::msg_t                   msg,
  output logic                              res_valid,
  input  logic                              res_ready,
  output scpwm_pkg::res_t                   res,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [scpwm_pkg::CMP_W-1:0]       cfg_period
);
  import scpwm_pkg::*;

  seq_state_t state, state_next;

  logic [CMP_W-1:0]        period;
  logic [IDX_W-1:0]        byte_index;
  logic [BYTE_W-1:0]       command_code;
  logic signed [ACC_W-1:0] angle_acc [CHANNELS];
  logic signed [ACC_W-1:0] direct_acc;
  logic [CMP_W-1:0]        cmp_val [CHANNELS];

  // Sequencer working registers
  logic [CH_W-1:0]          ch;
  logic                     dir;
  logic                     direct;
  logic [2:0]               status;
  logic [CHANNELS-1:0]      mask;
  logic signed [ACC_W-1:0]  pulse;
  logic [PT_W-1:0]          k;
  logic [T_W-1:0]           t;
  logic signed [PROD_W-1:0] prod;

  // Byte decode
  logic                     msg_fire;
  logic [IDX_W-1:0]         pos;
  logic [CH_W-1:0]          byte_ch;
  logic [DIG_W-1:0]         byte_dig;
  logic [BYTE_W+WGT_W-1:0]  digit_prod;
  logic signed [ACC_W-1:0]  digit_add;

  // Interpolation datapath
  logic signed [ACC_W-1:0]  angle;
  logic                     angle_neg;
  logic                     angle_hi;
  logic [CAL_W-1:0]         p_lo;
  logic [CAL_W-1:0]         p_hi;
  logic signed [CAL_W:0]    diff;
  logic [BASE_W-1:0]        base;
  logic signed [SUM_W-1:0]  sum_full;
  logic signed [ACC_W+1:0]  cmp_diff;
  logic [CMP_W-1:0]         cmp_new;

  logic                     div_start;
  logic [DIVIDEND_W-1:0]    div_dividend;
  div_stat_t                div;

  scpwm_div1k u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .stat     (div)
  );

  assign cfg_ready = 1'b1;
  assign msg_fire  = msg_valid && msg_ready;

  // Digit position within the message body
  always_comb begin
    pos        = byte_index - 1'b1;
    byte_ch    = CH_W'(pos / DIGITS);
    byte_dig   = DIG_W'(pos % DIGITS);
    digit_prod = (BYTE_W + WGT_W)'(msg.message_byte) *
                 (BYTE_W + WGT_W)'(digit_weight(byte_dig));
    digit_add  = $signed(ACC_W'(digit_prod));
  end

  // Interpolation: segment k, offset t, rounding half up via the divider
  always_comb begin
    angle     = angle_acc[ch];
    angle_neg = angle[ACC_W-1];
    angle_hi  = !angle_neg && (angle >= ACC_W'(ANGLE_TOP));
    p_lo      = cal_point(dir, ch, k);
    p_hi      = cal_point(dir, ch, PT_W'(k + 1'b1));
    diff      = $signed({1'b0, p_hi}) - $signed({1'b0, p_lo});
    base      = BASE_W'(BASE_W'(p_lo) * BASE_W'(SEG_SPAN));
    sum_full  = $signed(SUM_W'(base)) + SUM_W'(prod) + SUM_W'(HALF_SPAN);
  end

  // Compare = period - pulse, clamped to 0..period
  always_comb begin
    cmp_diff = $signed({2'b00, ACC_W'(period)}) - (ACC_W + 2)'(pulse);
    if (cmp_diff[ACC_W+1]) begin
      cmp_new = '0;
    end else if (cmp_diff > $signed({2'b00, ACC_W'(period)})) begin
      cmp_new = period;
    end else begin
      cmp_new = cmp_diff[CMP_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= SQ_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    msg_ready    = 1'b0;
    div_start    = 1'b0;
    div_dividend = '0;
    unique case (state)
      SQ_IDLE: begin
        msg_ready = 1'b1;
        if (msg_valid && msg.end_of_message) begin
          state_next = SQ_DECODE;
        end
      end
      SQ_DECODE: begin
        unique case (command_code) inside
          CMD_REV, CMD_FWD:     state_next = SQ_CHAN;
          CMD_A, CMD_B, CMD_C:  state_next = SQ_APPLY;
          default:              state_next = SQ_DONE;
        endcase
      end
      SQ_CHAN: begin
        if (angle_neg || angle_hi) begin
          state_next = SQ_APPLY;
        end else begin
          div_start    = 1'b1;
          div_dividend = DIVIDEND_W'($unsigned(angle));
          state_next   = SQ_KDIV;
        end
      end
      SQ_KDIV: begin
        if (div.done) begin
          state_next = SQ_MUL;
        end
      end
      SQ_MUL: begin
        state_next = SQ_SUM;
      end
      SQ_SUM: begin
        div_start    = 1'b1;
        div_dividend = DIVIDEND_W'($unsigned(sum_full));
        state_next   = SQ_PDIV;
      end
      SQ_PDIV: begin
        if (div.done) begin
          state_next = SQ_APPLY;
        end
      end
      SQ_APPLY: begin
        if (direct || ch == CH_W'(CHANNELS - 1)) begin
          state_next = SQ_DONE;
        end else begin
          state_next = SQ_CHAN;
        end
      end
      SQ_DONE: begin
        if (!res_valid || res_ready) begin
          state_next = SQ_IDLE;
        end
      end
      default: begin
        state_next = SQ_IDLE;
      end
    endcase
  end

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      period <= PERIOD_RESET;
    end else if (cfg_valid && cfg_ready) begin
      period <= cfg_period;
    end
  end

  // Message capture, channel updates and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_index   <= '0;
      command_code <= CMD_NONE;
      direct_acc   <= ACC_INIT;
      res_valid    <= 1'b0;
      status       <= STAT_IGNORED;
      mask         <= '0;
      for (int c = 0; c < CHANNELS; c++) begin
        angle_acc[c] <= ACC_INIT;
        cmp_val[c]   <= NEUTRAL_CMP;
      end
    end else begin
      // Issue a result when the register is free or being emptied
      if (state == SQ_DONE && (!res_valid || res_ready)) begin
        res_valid <= 1'b1;
      end else if (res_valid && res_ready) begin
        res_valid <= 1'b0;
      end

      unique case (state)
        SQ_IDLE: begin
          if (msg_fire) begin
            // Byte 0 is the command; digits follow; drop bytes past the last
            if (byte_index == '0) begin
              command_code <= msg.message_byte;
            end else if (byte_index < IDX_W'(LAST_POS)) begin
              for (int c = 0; c < CHANNELS; c++) begin
                if (byte_ch == CH_W'(c)) begin
                  angle_acc[c] <= angle_acc[c] + digit_add;
                end
              end
              if (byte_ch == '0) begin
                direct_acc <= direct_acc + digit_add;
              end
            end
            if (byte_index < IDX_W'(LAST_POS)) begin
              byte_index <= byte_index + 1'b1;
            end
          end
        end
        SQ_DECODE: begin
          mask   <= '0;
          direct <= 1'b0;
          unique case (command_code) inside
            CMD_NONE: begin
              status <= STAT_IGNORED;
            end
            CMD_REV, CMD_FWD: begin
              status <= (command_code == CMD_FWD) ? STAT_FORWARD : STAT_REVERSE;
              dir    <= (command_code == CMD_FWD);
              ch     <= '0;
            end
            CMD_A, CMD_B, CMD_C: begin
              // All three direct channels exist in this build
              status <= STAT_DIRECT;
              direct <= 1'b1;
              ch     <= CH_W'(command_code - CMD_A);
              pulse  <= direct_acc;
            end
            default: begin
              status <= STAT_UNKNOWN;
            end
          endcase
        end
        SQ_CHAN: begin
          // Clamp to the end points outside the table span
          if (angle_neg) begin
            pulse <= $signed(ACC_W'(cal_point(dir, ch, '0)));
          end else if (angle_hi) begin
            pulse <= $signed(ACC_W'(cal_point(dir, ch, PT_W'(CAL_POINTS - 1))));
          end
        end
        SQ_KDIV: begin
          if (div.done) begin
            k <= PT_W'(div.quot);
            t <= div.rem;
          end
        end
        SQ_MUL: begin
          prod <= PROD_W'(diff * $signed({1'b0, t}));
        end
        SQ_PDIV: begin
          if (div.done) begin
            pulse <= $signed(ACC_W'(div.quot));
          end
        end
        SQ_APPLY: begin
          for (int c = 0; c < CHANNELS; c++) begin
            if (ch == CH_W'(c)) begin
              cmp_val[c] <= cmp_new;
              mask[c]    <= mask[c] | (cmp_new != cmp_val[c]);
            end
          end
          ch <= ch + 1'b1;
        end
        SQ_DONE: begin
          if (!res_valid || res_ready) begin
            res.status      <= status;
            res.update_mask <= 3'(mask);
            res.compare_a   <= cmp_val[0];
            res.compare_b   <= cmp_val[1];
            res.compare_c   <= cmp_val[2];
            // Return message state to its reset values
            byte_index   <= '0;
            command_code <= CMD_NONE;
            direct_acc   <= ACC_INIT;
            for (int c = 0; c < CHANNELS; c++) begin
              angle_acc[c] <= ACC_INIT;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  `SCPWM_ASSERT_IMP(a_no_mask_idle, clk, rst, res_valid && (res.status == STAT_IGNORED || res.status == STAT_UNKNOWN), res.update_mask == 3'b000, "mask set without update")
  `SCPWM_ASSERT_IMP(a_direct_one, clk, rst, res_valid && res.status == STAT_DIRECT, $onehot0(res.update_mask), "direct command touched several channels")
  `SCPWM_ASSERT_IMP(a_idle_div, clk, rst, msg_ready, !div.busy, "divider busy while taking bytes")
  `SCPWM_ASSERT_NXT(a_last_stops, clk, rst, msg_fire && msg.end_of_message, !msg_ready, "bytes taken after message end")

endmodule

`default_nettype wire
